[rtl/core/tcw_pkg.sv]
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int REQ_W   = 2;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 8;
  localparam int CELL_W  = CHAR_W + COLOR_W;
  localparam int IDX_W   = 11;
  localparam int POS_W   = 11;
  localparam int COUNT_W = 12;

  localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
  localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'd32;
  localparam logic [3:0]         RESET_FG     = 4'hA;
  localparam logic [3:0]         RESET_BG     = 4'h0;
  localparam logic [COLOR_W-1:0] RESET_COLOR  = {RESET_BG, RESET_FG};

  typedef enum logic [REQ_W-1:0] {
    REQ_PUT       = 2'd0,
    REQ_BACKSPACE = 2'd1,
    REQ_READ      = 2'd2
  } req_code_t;

  typedef struct packed {
    logic take_req;
    logic exec;
    logic init_step;
    logic scroll_step;
    logic scan_clr;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic need_scroll;
    logic scan_last;
    logic out_free;
  } ctl_status_t;

endpackage

[rtl/core/tcw_req_if.sv]
interface tcw_req_if;
  logic                       valid;
  logic                       ready;
  logic [tcw_pkg::REQ_W-1:0]  req_type;
  logic [tcw_pkg::CHAR_W-1:0] char_code;
  logic [tcw_pkg::IDX_W-1:0]  cell_index;

  modport source (output valid, output req_type, output char_code, output cell_index,
                  input ready);
  modport sink (input valid, input req_type, input char_code, input cell_index,
                output ready);
endinterface

[rtl/core/tcw_rsp_if.sv]
interface tcw_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [tcw_pkg::POS_W-1:0]  cursor_position;
  logic [tcw_pkg::CELL_W-1:0] cell_value;
  logic                       did_scroll;

  modport source (output valid, output cursor_position, output cell_value,
                  output did_scroll, input ready);
  modport sink (input valid, input cursor_position, input cell_value,
                input did_scroll, output ready);
endinterface

[rtl/core/text_console_writer_unit.sv]
// Text console engine holding a ROWS x COLUMNS screen of 16-bit cells (character in the low
// byte, attribute in the high byte) in a single memory with one write and one read port.
// After reset the block walks that memory once, one cell per cycle, to fill it with spaces in
// the reset attribute, so the input stays not ready until the last cell has been written;
// attribute writes on the cfg port are taken at any time. Put, backspace and read requests
// pass through an execute state and a done state, and the result is registered in the done
// state, where the block also takes the next request while the result port keeps up. A put
// that moves the cursor past the bottom row scrolls the screen by copying every cell one row
// up through the memory port and blanking the last row, in a scroll state that visits every cell.
module text_console_writer_unit #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  tcw_req_if.sink                     in_chan,
  tcw_rsp_if.source                   out_chan,
  input  logic                        cfg_wr_en,
  input  logic [tcw_pkg::COLOR_W-1:0] cfg_wr_data
);

  tcw_pkg::ctl_cmd_t    cmd;
  tcw_pkg::ctl_status_t status;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .status   (status),
    .cmd      (cmd)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .in_req_type         (in_chan.req_type),
    .in_char_code        (in_chan.char_code),
    .in_cell_index       (in_chan.cell_index),
    .out_ready           (out_chan.ready),
    .out_valid           (out_chan.valid),
    .out_cursor_position (out_chan.cursor_position),
    .out_cell_value      (out_chan.cell_value),
    .out_did_scroll      (out_chan.did_scroll),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data)
  );

  // Every transfer on the input must be followed by the execute step.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> cmd.exec)
    else $error("accepted request was not executed");

  // A result is only loaded when the output register is free or being drained.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_chan.valid || out_chan.ready))
    else $error("pending result overwritten");

  // Only put requests scroll, and those never return cell data.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.did_scroll) |-> (out_chan.cell_value == '0))
    else $error("scrolling result carries cell data");

endmodule

[rtl/core/tcw_ctrl.sv]
module tcw_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tcw_pkg::ctl_status_t status,
  output tcw_pkg::ctl_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_SCROLL,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   take;

  always_comb begin
    in_ready = (state_r == S_IDLE) || ((state_r == S_DONE) && status.out_free);
    take     = in_valid && in_ready;

    cmd.take_req    = take;
    cmd.exec        = (state_r == S_EXEC);
    cmd.init_step   = (state_r == S_INIT);
    cmd.scroll_step = (state_r == S_SCROLL);
    cmd.scan_clr    = (state_r == S_EXEC);
    cmd.load_out    = (state_r == S_DONE) && status.out_free;

    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        if (status.scan_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (take) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = status.need_scroll ? S_SCROLL : S_DONE;
      end
      S_SCROLL: begin
        if (status.scan_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          state_nxt = take ? S_EXEC : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/core/tcw_datapath.sv]
module tcw_datapath #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tcw_pkg::ctl_cmd_t            cmd,
  output tcw_pkg::ctl_status_t         status,
  input  logic [tcw_pkg::REQ_W-1:0]    in_req_type,
  input  logic [tcw_pkg::CHAR_W-1:0]   in_char_code,
  input  logic [tcw_pkg::IDX_W-1:0]    in_cell_index,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [tcw_pkg::POS_W-1:0]    out_cursor_position,
  output logic [tcw_pkg::CELL_W-1:0]   out_cell_value,
  output logic                         out_did_scroll,
  input  logic                         cfg_wr_en,
  input  logic [tcw_pkg::COLOR_W-1:0]  cfg_wr_data
);

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int COPY_COUNT = CELL_COUNT - COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int COL_W      = $clog2(COLUMNS);

  localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);
  localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] COPY_LIMIT = ADDR_W'(COPY_COUNT);
  localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);

  logic [tcw_pkg::CELL_W-1:0] mem [CELL_COUNT];

  logic [tcw_pkg::REQ_W-1:0]   req_type_r;
  logic [tcw_pkg::CHAR_W-1:0]  char_code_r;
  logic [tcw_pkg::IDX_W-1:0]   cell_index_r;
  logic                        in_range_r;
  logic [tcw_pkg::COLOR_W-1:0] color_r;
  logic [ROW_W-1:0]            row_r;
  logic [ROW_W-1:0]            row_nxt;
  logic [COL_W-1:0]            col_r;
  logic [COL_W-1:0]            col_nxt;
  logic [tcw_pkg::COUNT_W-1:0] count_r;
  logic [tcw_pkg::COUNT_W-1:0] count_nxt;
  logic                        scrolled_r;
  logic [ADDR_W-1:0]           scan_r;
  logic                        pipe_wr_r;
  logic                        pipe_copy_r;
  logic [ADDR_W-1:0]           pipe_addr_r;
  logic [tcw_pkg::CELL_W-1:0]  rd_data_r;

  logic                        need_scroll;
  logic                        ex_we;
  logic                        ex_rd;
  logic [ROW_W-1:0]            wr_row;
  logic [COL_W-1:0]            wr_col;
  logic [tcw_pkg::CHAR_W-1:0]  ex_char;
  logic [ADDR_W-1:0]           ex_addr;
  logic                        scan_copy;
  logic                        mem_we;
  logic [ADDR_W-1:0]           mem_waddr;
  logic [tcw_pkg::CELL_W-1:0]  mem_wdata;
  logic                        mem_re;
  logic [ADDR_W-1:0]           mem_raddr;
  logic [tcw_pkg::CELL_W-1:0]  blank_cell;

  always_comb begin
    row_nxt     = row_r;
    col_nxt     = col_r;
    count_nxt   = count_r;
    need_scroll = 1'b0;
    ex_we       = 1'b0;
    ex_rd       = 1'b0;
    ex_char     = char_code_r;
    wr_row      = row_r;
    wr_col      = col_r;
    case (req_type_r)
      tcw_pkg::REQ_PUT: begin
        if (char_code_r == tcw_pkg::NEWLINE_CODE) begin
          col_nxt   = '0;
          count_nxt = '0;
          if (row_r == LAST_ROW) begin
            need_scroll = 1'b1;
          end else begin
            row_nxt = row_r + ROW_W'(1);
          end
        end else begin
          ex_we = 1'b1;
          if (count_r != tcw_pkg::COUNT_MAX) begin
            count_nxt = count_r + tcw_pkg::COUNT_W'(1);
          end
          if (col_r == LAST_COL) begin
            col_nxt = '0;
            if (row_r == LAST_ROW) begin
              need_scroll = 1'b1;
            end else begin
              row_nxt = row_r + ROW_W'(1);
            end
          end else begin
            col_nxt = col_r + COL_W'(1);
          end
        end
      end
      tcw_pkg::REQ_BACKSPACE: begin
        if ((count_r != '0) && !((row_r == '0) && (col_r == '0))) begin
          ex_we     = 1'b1;
          ex_char   = tcw_pkg::SPACE_CODE;
          count_nxt = count_r - tcw_pkg::COUNT_W'(1);
          if (col_r == '0) begin
            row_nxt = row_r - ROW_W'(1);
            col_nxt = LAST_COL;
          end else begin
            col_nxt = col_r - COL_W'(1);
          end
          wr_row = row_nxt;
          wr_col = col_nxt;
        end
      end
      tcw_pkg::REQ_READ: begin
        ex_rd = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign ex_addr    = ADDR_W'(32'(wr_row) * COLUMNS + 32'(wr_col));
  assign blank_cell = {color_r, tcw_pkg::SPACE_CODE};
  assign scan_copy  = (scan_r < COPY_LIMIT);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = scan_r;
    mem_wdata = {tcw_pkg::RESET_COLOR, tcw_pkg::SPACE_CODE};
    if (pipe_wr_r) begin
      mem_we    = 1'b1;
      mem_waddr = pipe_addr_r;
      mem_wdata = pipe_copy_r ? rd_data_r : blank_cell;
    end else if (cmd.init_step) begin
      mem_we = 1'b1;
    end else if (cmd.exec && ex_we) begin
      mem_we    = 1'b1;
      mem_waddr = ex_addr;
      mem_wdata = {color_r, ex_char};
    end
  end

  always_comb begin
    if (cmd.scroll_step) begin
      mem_re    = scan_copy;
      mem_raddr = scan_r + ROW_STRIDE;
    end else begin
      mem_re    = cmd.exec && ex_rd;
      mem_raddr = ADDR_W'(cell_index_r);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_req) begin
      req_type_r   <= in_req_type;
      char_code_r  <= in_char_code;
      cell_index_r <= in_cell_index;
      in_range_r   <= (32'(in_cell_index) < CELL_COUNT);
    end
    if (cmd.scroll_step) begin
      pipe_addr_r <= scan_r;
      pipe_copy_r <= scan_copy;
    end
    if (cmd.load_out) begin
      out_cursor_position <= tcw_pkg::POS_W'(32'(row_r) * COLUMNS + 32'(col_r));
      out_cell_value      <= ((req_type_r == tcw_pkg::REQ_READ) && in_range_r) ?
                             rd_data_r : '0;
      out_did_scroll      <= scrolled_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r    <= tcw_pkg::RESET_COLOR;
      row_r      <= '0;
      col_r      <= '0;
      count_r    <= '0;
      scrolled_r <= 1'b0;
      scan_r     <= '0;
      pipe_wr_r  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        color_r <= cfg_wr_data;
      end
      if (cmd.exec) begin
        row_r      <= row_nxt;
        col_r      <= col_nxt;
        count_r    <= count_nxt;
        scrolled_r <= need_scroll;
      end
      if (cmd.scan_clr) begin
        scan_r <= '0;
      end else if (cmd.init_step || cmd.scroll_step) begin
        scan_r <= (scan_r == LAST_CELL) ? '0 : scan_r + ADDR_W'(1);
      end
      pipe_wr_r <= cmd.scroll_step;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.need_scroll = need_scroll;
  assign status.scan_last   = (scan_r == LAST_CELL);
  assign status.out_free    = !out_valid || out_ready;

endmodule

[tb/tb_text_console_writer_unit.sv]
`timescale 1ns / 1ps

module tb_text_console_writer_unit;

  localparam int COLS  = tcw_pkg::COLUMNS_DEF;
  localparam int ROWS  = tcw_pkg::ROWS_DEF;
  localparam int CELLS = ROWS * COLS;
  localparam logic [tcw_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [tcw_pkg::POS_W-1:0]  cursor_position;
    logic [tcw_pkg::CELL_W-1:0] cell_value;
    logic                       did_scroll;
  } console_result_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [tcw_pkg::COLOR_W-1:0] cfg_wr_data;

  tcw_req_if req_chan();
  tcw_rsp_if rsp_chan();

  text_console_writer_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (req_chan),
    .out_chan    (rsp_chan),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  logic [tcw_pkg::CELL_W-1:0]  screen_model [CELLS];
  int                          cur_row;
  int                          cur_col;
  logic [tcw_pkg::COUNT_W-1:0] typed_model;
  logic [tcw_pkg::COLOR_W-1:0] color_model;

  console_result_t pending_results [$];

  int  errors;
  int  sent_count;
  int  checked_count;
  int  scroll_count;
  int  color_writes;
  int  hold_requests;
  bit  sender_idle;
  bit  sink_idle;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(200_000_000);
    $display("status: fail");
    $finish;
  end

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 55) begin
      return 0;
    end
    return pick_len();
  endfunction

  function automatic void reset_console_model();
    int i;
    for (i = 0; i < CELLS; i++) begin
      screen_model[i] = {tcw_pkg::RESET_COLOR, tcw_pkg::SPACE_CODE};
    end
    cur_row     = 0;
    cur_col     = 0;
    typed_model = '0;
    color_model = tcw_pkg::RESET_COLOR;
  endfunction

  function automatic logic advance_cursor_row();
    int i;
    cur_col = 0;
    if (cur_row + 1 >= ROWS) begin
      for (i = 0; i < CELLS - COLS; i++) begin
        screen_model[i] = screen_model[i + COLS];
      end
      for (i = CELLS - COLS; i < CELLS; i++) begin
        screen_model[i] = {color_model, tcw_pkg::SPACE_CODE};
      end
      return 1'b1;
    end
    cur_row++;
    return 1'b0;
  endfunction

  function automatic console_result_t apply_console_request(
      input logic [tcw_pkg::REQ_W-1:0] req,
      input logic [tcw_pkg::CHAR_W-1:0] ch,
      input logic [tcw_pkg::IDX_W-1:0] idx);
    console_result_t res;
    res = '0;
    case (req)
      tcw_pkg::REQ_PUT: begin
        if (ch == tcw_pkg::NEWLINE_CODE) begin
          res.did_scroll = advance_cursor_row();
          typed_model = '0;
        end else begin
          screen_model[cur_row * COLS + cur_col] = {color_model, ch};
          if (typed_model != tcw_pkg::COUNT_MAX) begin
            typed_model++;
          end
          cur_col++;
          if (cur_col >= COLS) begin
            res.did_scroll = advance_cursor_row();
          end
        end
      end
      tcw_pkg::REQ_BACKSPACE: begin
        if (typed_model != '0 && !(cur_row == 0 && cur_col == 0)) begin
          if (cur_col == 0) begin
            cur_row--;
            cur_col = COLS - 1;
          end else begin
            cur_col--;
          end
          screen_model[cur_row * COLS + cur_col] = {color_model, tcw_pkg::SPACE_CODE};
          typed_model--;
        end
      end
      tcw_pkg::REQ_READ: begin
        if (idx < CELLS) begin
          res.cell_value = screen_model[idx];
        end
      end
      default: begin
      end
    endcase
    res.cursor_position = tcw_pkg::POS_W'(cur_row * COLS + cur_col);
    if (res.did_scroll) begin
      scroll_count++;
    end
    return res;
  endfunction

  task automatic send_request(input logic [tcw_pkg::REQ_W-1:0] req,
                              input logic [tcw_pkg::CHAR_W-1:0] ch,
                              input logic [tcw_pkg::IDX_W-1:0] idx);
    int gap;
    req_chan.valid      <= 1'b1;
    req_chan.req_type   <= req;
    req_chan.char_code  <= ch;
    req_chan.cell_index <= idx;
    do @(posedge clk); while (!req_chan.ready);
    pending_results.push_back(apply_console_request(req, ch, idx));
    sent_count++;
    gap = sender_idle ? pick_gap() : 0;
    if (gap > 0) begin
      req_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_all_results();
    req_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_text_color(input logic [tcw_pkg::COLOR_W-1:0] color);
    wait_all_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= color;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    color_model = color;
    color_writes++;
  endtask

  task automatic send_random_request();
    int pick;
    int near;
    logic [tcw_pkg::CHAR_W-1:0] ch;
    logic [tcw_pkg::IDX_W-1:0] idx;
    pick = $urandom_range(0, 99);
    ch   = tcw_pkg::CHAR_W'($urandom_range(0, 255));
    idx  = tcw_pkg::IDX_W'($urandom_range(0, 2047));
    if (pick < 66) begin
      if ($urandom_range(0, 24) == 0) begin
        ch = tcw_pkg::NEWLINE_CODE;
      end
      send_request(tcw_pkg::REQ_PUT, ch, idx);
    end else if (pick < 80) begin
      send_request(tcw_pkg::REQ_BACKSPACE, ch, idx);
    end else if (pick < 97) begin
      near = $urandom_range(0, 99);
      if (near < 80) begin
        idx = tcw_pkg::IDX_W'($urandom_range(0, CELLS - 1));
      end else if (near < 94) begin
        idx = tcw_pkg::IDX_W'(cur_row * COLS + cur_col);
        if (idx > tcw_pkg::IDX_W'(0)) begin
          idx = idx - tcw_pkg::IDX_W'(1);
        end
      end else begin
        idx = tcw_pkg::IDX_W'($urandom_range(CELLS, 2047));
      end
      send_request(tcw_pkg::REQ_READ, ch, idx);
    end else begin
      send_request(REQ_UNUSED, ch, idx);
    end
  endtask

  task automatic test_directed_requests();
    sender_idle = 1'b1;
    sink_idle   = 1'b1;
    send_request(tcw_pkg::REQ_READ, 8'h00, 11'd0);
    send_request(tcw_pkg::REQ_READ, 8'hFF, 11'd1999);
    send_request(tcw_pkg::REQ_READ, 8'h00, 11'd2000);
    send_request(tcw_pkg::REQ_READ, 8'h00, 11'h7FF);
    send_request(REQ_UNUSED, 8'hFF, 11'h7FF);
    send_request(tcw_pkg::REQ_BACKSPACE, 8'h00, 11'd0);
    send_request(tcw_pkg::REQ_PUT, 8'h41, 11'd0);
    send_request(tcw_pkg::REQ_PUT, 8'h00, 11'd0);
    send_request(tcw_pkg::REQ_PUT, 8'hFF, 11'h7FF);
    send_request(tcw_pkg::REQ_READ, 8'h00, 11'd2);
    send_request(tcw_pkg::REQ_BACKSPACE, 8'h00, 11'd0);
    send_request(tcw_pkg::REQ_READ, 8'h00, 11'd2);
    send_request(tcw_pkg::REQ_PUT, tcw_pkg::NEWLINE_CODE, 11'd0);
    send_request(tcw_pkg::REQ_BACKSPACE, 8'h00, 11'd0);
    send_request(tcw_pkg::REQ_PUT, 8'h7E, 11'd0);
    send_request(tcw_pkg::REQ_BACKSPACE, 8'h00, 11'd0);
    send_request(tcw_pkg::REQ_BACKSPACE, 8'h00, 11'd0);
    send_request(tcw_pkg::REQ_READ, 8'h00, 11'd80);
    send_request(tcw_pkg::REQ_READ, 8'h00, 11'd0);
    send_request(tcw_pkg::REQ_READ, 8'h00, 11'd1);
  endtask

  task automatic test_text_colors();
    logic [tcw_pkg::COLOR_W-1:0] colors [5];
    int p;
    int n;
    colors[0] = 8'h00;
    colors[1] = 8'hFF;
    colors[2] = tcw_pkg::COLOR_W'($urandom_range(0, 255));
    colors[3] = tcw_pkg::COLOR_W'($urandom_range(0, 255));
    colors[4] = tcw_pkg::RESET_COLOR;
    for (p = 0; p < 5; p++) begin
      set_text_color(colors[p]);
      sender_idle = (p != 1);
      sink_idle   = (p != 1) && (p != 3);
      for (n = 0; n < 200; n++) begin
        send_random_request();
      end
    end
  endtask

  task automatic test_result_backpressure();
    int n;
    wait_all_results();
    sender_idle = 1'b0;
    sink_idle   = 1'b0;
    hold_requests++;
    for (n = 0; n < 30; n++) begin
      send_random_request();
    end
    wait_all_results();
    sender_idle = 1'b1;
    sink_idle   = 1'b1;
    for (n = 0; n < 20; n++) begin
      send_random_request();
    end
  endtask

  task automatic test_long_line();
    int n;
    logic [tcw_pkg::CHAR_W-1:0] ch;
    sender_idle = 1'b0;
    sink_idle   = 1'b1;
    send_request(tcw_pkg::REQ_PUT, tcw_pkg::NEWLINE_CODE, 11'd0);
    for (n = 0; n < 150; n++) begin
      ch = tcw_pkg::CHAR_W'($urandom_range(0, 254));
      if (ch >= tcw_pkg::NEWLINE_CODE) begin
        ch = ch + tcw_pkg::CHAR_W'(1);
      end
      send_request(tcw_pkg::REQ_PUT, ch, tcw_pkg::IDX_W'($urandom_range(0, 2047)));
    end
    while (typed_model != '0 && (cur_row != 0 || cur_col != 0)) begin
      send_request(tcw_pkg::REQ_BACKSPACE, 8'h00, 11'd0);
    end
    send_request(tcw_pkg::REQ_BACKSPACE, 8'hFF, 11'h7FF);
    send_request(tcw_pkg::REQ_BACKSPACE, 8'h00, 11'd0);
    for (n = 0; n < 8; n++) begin
      send_request(tcw_pkg::REQ_READ, 8'h00, tcw_pkg::IDX_W'($urandom_range(0, CELLS - 1)));
    end
    send_request(tcw_pkg::REQ_PUT, tcw_pkg::NEWLINE_CODE, 11'd0);
  endtask

  task automatic test_mixed_traffic();
    int n;
    sender_idle = 1'b1;
    sink_idle   = 1'b1;
    for (n = 0; n < 600; n++) begin
      if (n == 300) begin
        sender_idle = 1'b0;
        sink_idle   = 1'b0;
      end
      send_random_request();
    end
  endtask

  always @(posedge clk) begin : drive_result_ready
    int stall_left;
    int hold_left;
    int holds_seen;
    if (holds_seen != hold_requests) begin
      holds_seen = hold_requests;
      hold_left  = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_chan.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_chan.ready <= 1'b0;
    end else begin
      rsp_chan.ready <= 1'b1;
      if (sink_idle && $urandom_range(0, 99) < 15) begin
        stall_left = pick_len();
      end
    end
  end

  always @(posedge clk) begin : check_results
    console_result_t want;
    if (rst_n && rsp_chan.valid && rsp_chan.ready) begin
      checked_count++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, cursor_position %0d cell_value %h did_scroll %0b",
                 $time, rsp_chan.cursor_position, rsp_chan.cell_value, rsp_chan.did_scroll);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_chan.cursor_position !== want.cursor_position) begin
          $display("%0t: cursor_position expected %0d actual %0d", $time,
                   want.cursor_position, rsp_chan.cursor_position);
          errors++;
        end
        if (rsp_chan.cell_value !== want.cell_value) begin
          $display("%0t: cell_value expected %h actual %h", $time,
                   want.cell_value, rsp_chan.cell_value);
          errors++;
        end
        if (rsp_chan.did_scroll !== want.did_scroll) begin
          $display("%0t: did_scroll expected %0b actual %0b", $time,
                   want.did_scroll, rsp_chan.did_scroll);
          errors++;
        end
      end
    end
  end

  initial begin
    sent_count    = 0;
    scroll_count  = 0;
    color_writes  = 0;
    hold_requests = 0;
    sender_idle   = 1'b1;
    sink_idle     = 1'b1;
    reset_console_model();
    rst_n               <= 1'b0;
    cfg_wr_en           <= 1'b0;
    cfg_wr_data         <= '0;
    req_chan.valid      <= 1'b0;
    req_chan.req_type   <= '0;
    req_chan.char_code  <= '0;
    req_chan.cell_index <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_requests();
    test_text_colors();
    test_result_backpressure();
    test_long_line();
    test_mixed_traffic();

    wait_all_results();
    repeat (20) @(posedge clk);
    $display("Sent %0d requests and checked %0d results; %0d of them scrolled the screen.",
             sent_count, checked_count, scroll_count);
    $display("The text color was written %0d times; %0d mismatches were found.",
             color_writes, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
